@@ rtl/tbp_pkg.sv @@
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types and codes for the two-button press duration classifier.
// ----------------------------------------------------------------------------
package tbp_pkg;

   localparam int unsigned TICK_W = 16;

   // key codes: bit 0 is button A, bit 1 is button B
   localparam logic [1:0] KEY_OFF  = 2'd0;
   localparam logic [1:0] KEY_A    = 2'd1;
   localparam logic [1:0] KEY_B    = 2'd2;
   localparam logic [1:0] KEY_BOTH = 2'd3;

   // press classes
   localparam logic [1:0] CLASS_NONE  = 2'd0;
   localparam logic [1:0] CLASS_SHORT = 2'd1;
   localparam logic [1:0] CLASS_LONG  = 2'd2;
   localparam logic [1:0] CLASS_VLONG = 2'd3;

   // register indexes
   localparam logic CSR_LONG_TICKS  = 1'b0;
   localparam logic CSR_VLONG_TICKS = 1'b1;

   localparam logic [TICK_W-1:0] LONG_TICKS_RESET  = 16'd300;
   localparam logic [TICK_W-1:0] VLONG_TICKS_RESET = 16'd700;
   localparam logic [TICK_W-1:0] HOLD_ONE          = 16'd1;
   localparam logic [TICK_W-1:0] HOLD_MAX          = 16'hFFFF;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_CONFIRM = 5'b00010,
      PH_HOLD1   = 5'b00100,
      PH_COUNT   = 5'b01000,
      PH_WAIT    = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [1:0] key_id;
      logic [1:0] press_class;
      logic       freq_mode;
      logic       alarm_mode;
   } result_type;

endpackage

@@ rtl/tbp_in_stage.sv @@
// ----------------------------------------------------------------------------
// tbp_in_stage
// Input register: captures one scan tick beat and encodes the key code.
// ----------------------------------------------------------------------------
module tbp_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_button_a_down,
   input  logic       req_button_b_down,
   input  logic       advance,
   output logic       in_valid,
   output logic [1:0] in_code
);
   import tbp_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [1:0] in_code_ff;
   logic       accept;

   // held beat only blocks new input while the result side is stalled
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_code_ff <= {req_button_b_down, req_button_a_down};
      end
   end

   assign in_valid = in_valid_ff;
   assign in_code  = in_code_ff;

endmodule

@@ rtl/tbp_classifier.sv @@
// ----------------------------------------------------------------------------
// tbp_classifier
// Press phase machine, hold counter, mode flags and threshold registers.
// ----------------------------------------------------------------------------
module tbp_classifier (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [tbp_pkg::TICK_W-1:0] csr_wdata,
   input  logic                      fire,
   input  logic [1:0]                code,
   output tbp_pkg::result_type       result
);
   import tbp_pkg::*;

   logic [TICK_W-1:0] long_ticks_ff;
   logic [TICK_W-1:0] vlong_ticks_ff;
   phase_type         phase_ff, phase_in;
   logic [1:0]        prev_ff, prev_in;
   logic [TICK_W-1:0] hold_ff, hold_in;
   logic              freq_ff, freq_in;
   logic              alarm_ff, alarm_in;
   logic [TICK_W-1:0] hold_inc;
   logic              in_vlong;
   logic              in_long;
   logic [1:0]        rep_key;
   logic [1:0]        rep_class;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ticks_ff  <= LONG_TICKS_RESET;
         vlong_ticks_ff <= VLONG_TICKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LONG_TICKS:  long_ticks_ff  <= csr_wdata;
            CSR_VLONG_TICKS: vlong_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // counter saturates at all ones
   assign hold_inc = (hold_ff == HOLD_MAX) ? hold_ff : hold_ff + HOLD_ONE;
   assign in_vlong = hold_inc > vlong_ticks_ff;
   assign in_long  = (hold_inc < vlong_ticks_ff) && (hold_inc > long_ticks_ff);

   always_comb begin
      phase_in  = phase_ff;
      prev_in   = code;
      hold_in   = hold_ff;
      freq_in   = freq_ff;
      alarm_in  = alarm_ff;
      rep_key   = KEY_OFF;
      rep_class = CLASS_NONE;
      unique case (phase_ff)
         PH_CONFIRM: begin
            phase_in = (code == prev_ff && code != KEY_OFF) ? PH_HOLD1 : PH_IDLE;
         end
         PH_HOLD1: begin
            if (code == prev_ff) begin
               phase_in = PH_COUNT;
            end else if (code == KEY_BOTH) begin
               // sliding into both buttons drops the press silently
               phase_in = PH_IDLE;
               hold_in  = '0;
               prev_in  = KEY_OFF;
            end else begin
               phase_in  = PH_IDLE;
               rep_key   = prev_ff;
               rep_class = CLASS_SHORT;
            end
         end
         PH_COUNT: begin
            hold_in = hold_inc;
            if (code == prev_ff) begin
               if (code == KEY_BOTH) begin
                  if (in_vlong) begin
                     freq_in  = 1'b1;
                     alarm_in = 1'b0;
                  end else if (in_long) begin
                     alarm_in = 1'b1;
                     freq_in  = 1'b0;
                  end
               end
            end else if (code == KEY_BOTH) begin
               phase_in = PH_IDLE;
               hold_in  = '0;
               prev_in  = KEY_OFF;
            end else begin
               rep_key = prev_ff;
               hold_in = '0;
               if (in_vlong) begin
                  phase_in  = PH_WAIT;
                  rep_class = CLASS_VLONG;
               end else if (in_long) begin
                  phase_in  = PH_IDLE;
                  rep_class = CLASS_LONG;
               end else begin
                  phase_in  = PH_IDLE;
                  rep_class = CLASS_SHORT;
               end
            end
         end
         PH_WAIT: begin
            if (code != prev_ff) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = (code != KEY_OFF && prev_ff == KEY_OFF) ? PH_CONFIRM : PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         prev_ff  <= KEY_OFF;
         hold_ff  <= '0;
         freq_ff  <= 1'b0;
         alarm_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         hold_ff  <= hold_in;
         freq_ff  <= freq_in;
         alarm_ff <= alarm_in;
      end
   end

   assign result.key_id      = rep_key;
   assign result.press_class = rep_class;
   assign result.freq_mode   = freq_in;
   assign result.alarm_mode  = alarm_in;

endmodule

@@ rtl/tbp_out_stage.sv @@
// ----------------------------------------------------------------------------
// tbp_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module tbp_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  tbp_pkg::result_type result,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_key_id,
   output logic [1:0]          rsp_press_class,
   output logic                rsp_freq_mode,
   output logic                rsp_alarm_mode
);
   import tbp_pkg::*;

   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_id      = rsp_data_ff.key_id;
   assign rsp_press_class = rsp_data_ff.press_class;
   assign rsp_freq_mode   = rsp_data_ff.freq_mode;
   assign rsp_alarm_mode  = rsp_data_ff.alarm_mode;

endmodule

@@ rtl/two_button_press_duration_classifier.sv @@
// ----------------------------------------------------------------------------
// two_button_press_duration_classifier
// Classifies two-button presses as short, long or very long per scan tick.
// ----------------------------------------------------------------------------
// Each req beat is one scan tick with the two button levels; every tick gives
// exactly one rsp beat, presented on the rsp port after passing the input
// register, then the phase machine and compare logic feeding the result
// register. A new tick is taken every cycle while the result side keeps up.
// A press is reported on the tick where the key code changes. The user must
// see that long_ticks and very_long_ticks are written through the csr port
// while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module two_button_press_duration_classifier (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [tbp_pkg::TICK_W-1:0] csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_button_a_down,
   input  logic                       req_button_b_down,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_key_id,
   output logic [1:0]                 rsp_press_class,
   output logic                       rsp_freq_mode,
   output logic                       rsp_alarm_mode
);
   import tbp_pkg::*;

   logic       advance;
   logic       in_valid;
   logic [1:0] in_code;
   result_type result;

   tbp_in_stage u_in_stage (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_button_a_down (req_button_a_down),
      .req_button_b_down (req_button_b_down),
      .advance           (advance),
      .in_valid          (in_valid),
      .in_code           (in_code)
   );

   tbp_classifier u_classifier (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (in_valid && advance),
      .code      (in_code),
      .result    (result)
   );

   tbp_out_stage u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (in_valid),
      .result          (result),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_id      (rsp_key_id),
      .rsp_press_class (rsp_press_class),
      .rsp_freq_mode   (rsp_freq_mode),
      .rsp_alarm_mode  (rsp_alarm_mode)
   );

endmodule

@@ rtl/tbp_checker.sv @@
// ----------------------------------------------------------------------------
// tbp_checker
// Port-level checks for the two-button press duration classifier.
// ----------------------------------------------------------------------------
module tbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_key_id,
   input logic [1:0] rsp_press_class,
   input logic       rsp_freq_mode,
   input logic       rsp_alarm_mode
);
   import tbp_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_id)
         && $stable(rsp_press_class) && $stable(rsp_freq_mode)
         && $stable(rsp_alarm_mode))
      else $error("stalled rsp beat changed");

   // input only backs up behind a stalled result
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without rsp backpressure");

   // a key is named exactly when a press is reported
   a_key_with_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_key_id == KEY_OFF) == (rsp_press_class == CLASS_NONE)))
      else $error("key and class disagree");

   // the two mode flags never stand together
   a_modes_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_freq_mode && rsp_alarm_mode))
      else $error("freq and alarm mode both set");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind two_button_press_duration_classifier tbp_checker u_tbp_checker (.*);
